// ===== rtl/harris_window_response_unit_defines.svh =====
// ----------------------------------------------------------------------------
// harris window response unit: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef HARRIS_WINDOW_RESPONSE_UNIT_DEFINES_SVH
`define HARRIS_WINDOW_RESPONSE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HWR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hwr_pkg.sv =====
// ----------------------------------------------------------------------------
// hwr_pkg
// widths, reset values, register indexes and finish sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package hwr_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned SIZE_W   = 6;
  localparam int unsigned K_W      = 16;
  localparam int unsigned K_FRAC   = 16;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned COLSUM_W = PIX_W + 2;
  localparam int unsigned GRAD_W   = PIX_W + 3;
  localparam int unsigned SQ_W     = 20;
  localparam int unsigned XYP_W    = 21;

  localparam int unsigned SXX_W    = 30;
  localparam int unsigned SXY_W    = 31;
  localparam int unsigned RESP_W   = 63;
  localparam int unsigned TRACE_W  = SXX_W + 1;
  localparam int unsigned TSQ_W    = 2 * TRACE_W;
  localparam int unsigned TSQ_LO_W = 32;
  localparam int unsigned TSQ_HI_W = TSQ_W - TSQ_LO_W;

  localparam int unsigned DEFAULT_MAX_WIDTH = 32;

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(32);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(7);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(7);
  localparam logic [K_W-1:0]    K_RESET      = K_W'(6554);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_K_FIXED       = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_MUL,
    FIN_SQ,
    FIN_KMUL,
    FIN_KSUM,
    FIN_RESP
  } fin_state_t;

endpackage

`default_nettype wire

// ===== rtl/hwr_if.sv =====
// ----------------------------------------------------------------------------
// hwr channel interfaces
// pixel input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface hwr_pixel_if import hwr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface hwr_result_if import hwr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RESP_W-1:0] response;
  logic        [SXX_W-1:0]  sum_xx;
  logic        [SXX_W-1:0]  sum_yy;
  logic signed [SXY_W-1:0]  sum_xy;

  modport source (output valid, output response, output sum_xx, output sum_yy,
                  output sum_xy, input ready);
  modport sink   (input valid, input response, input sum_xx, input sum_yy,
                  input sum_xy, output ready);
endinterface

`default_nettype wire

// ===== rtl/harris_window_response_unit.sv =====
// ----------------------------------------------------------------------------
// harris window response unit
// streaming 3x3 sobel gradients over one window, structure tensor sums and
// the harris response det - k*trace^2 once per window
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  pixels    in   one 8-bit grayscale pixel, raster order
//  results   out  response, sum_xx, sum_yy, sum_xy, one beat per window
//  cfg_*     in   register write: window_width, window_height, k_fixed
//
// one pixel per cycle except while the pixel closing a window is held off; row store is
// one 16-bit synchronous ram, read then written back; the result beat follows the last pixel
// of a window through three gradient/accumulate stages then five finish steps and waits
// for a free output register; the last pixel of a window is held off while the finish sequencer
// is busy, which covers a finished result still waiting for the output register to free
// synchronous reset clears counters, sums and valids; row store needs no clear
//
`default_nettype none
`include "harris_window_response_unit_defines.svh"

module harris_window_response_unit import hwr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  hwr_pixel_if.sink            pixels,
  hwr_result_if.source         results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_WIDTH_S = SIZE_W'(MAX_WIDTH);

  // configuration registers
  logic [SIZE_W-1:0] cfg_width;
  logic [SIZE_W-1:0] cfg_height;
  logic [K_W-1:0]    cfg_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      cfg_k      <= K_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_WIDTH:  cfg_width  <= cfg_data[SIZE_W-1:0];
        CFG_WINDOW_HEIGHT: cfg_height <= cfg_data[SIZE_W-1:0];
        CFG_K_FIXED:       cfg_k      <= cfg_data[K_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // sizes saturated to the supported range
  logic [SIZE_W-1:0] win_w;
  logic [SIZE_W-1:0] win_h;

  always_comb begin
    priority if (cfg_width < MIN_SIZE) begin
      win_w = MIN_SIZE;
    end else if (cfg_width > MAX_WIDTH_S) begin
      win_w = MAX_WIDTH_S;
    end else begin
      win_w = cfg_width;
    end
    priority if (cfg_height < MIN_SIZE) begin
      win_h = MIN_SIZE;
    end else if (cfg_height > HEIGHT_LIMIT) begin
      win_h = HEIGHT_LIMIT;
    end else begin
      win_h = cfg_height;
    end
  end

  // position of the next pixel
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              row_end_now;
  logic              win_end_now;
  logic              interior_now;
  logic              in_accept;

  fin_state_t fin_state;
  fin_state_t fin_state_next;

  assign col_inc      = SIZE_W'(col_count) + SIZE_W'(1);
  assign row_inc      = SIZE_W'(row_count) + SIZE_W'(1);
  assign row_end_now  = (col_inc >= win_w);
  assign win_end_now  = row_end_now && (row_inc >= win_h);
  assign interior_now = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));

  // the pixel closing a window waits until the finish sequencer is free
  assign pixels.ready = !(win_end_now && (fin_state != FIN_IDLE));
  assign in_accept    = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (!row_end_now) begin
        col_count <= col_inc[COL_W-1:0];
      end else begin
        col_count <= '0;
        if (!win_end_now) begin
          row_count <= row_inc[ROW_W-1:0];
        end else begin
          row_count <= '0;
        end
      end
    end
  end

  // row store: upper byte two rows back, lower byte one row back
  logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   rd_up;
  logic [PIX_W-1:0]   rd_lo;

  // stage 1: read data back, window shift and write back
  logic             s1_valid;
  logic             s1_int;
  logic             s1_end;
  logic [PIX_W-1:0] s1_pix;
  logic [COL_W-1:0] s1_col;

  assign rd_up = rd_data[2*PIX_W-1:PIX_W];
  assign rd_lo = rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data <= row_mem[col_count];
    end
    // the row moves down one slot, the new pixel becomes the lower byte
    if (s1_valid) begin
      row_mem[s1_col] <= {rd_lo, s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_int <= interior_now;
      s1_end <= win_end_now;
      s1_pix <= pixels.pixel;
      s1_col <= col_count;
    end
  end

  // 3x3 window, index 2 is the newest column
  logic [PIX_W-1:0] win_top [3];
  logic [PIX_W-1:0] win_mid [3];
  logic [PIX_W-1:0] win_bot [3];
  logic             s2_valid;
  logic             s2_int;
  logic             s2_end;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win_top[0] <= win_top[1];
      win_top[1] <= win_top[2];
      win_top[2] <= rd_up;
      win_mid[0] <= win_mid[1];
      win_mid[1] <= win_mid[2];
      win_mid[2] <= rd_lo;
      win_bot[0] <= win_bot[1];
      win_bot[1] <= win_bot[2];
      win_bot[2] <= s1_pix;
      s2_int     <= s1_int;
      s2_end     <= s1_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // stage 2: sobel gradients and their products
  logic        [COLSUM_W-1:0]  sum_left;
  logic        [COLSUM_W-1:0]  sum_right;
  logic        [COLSUM_W-1:0]  sum_top;
  logic        [COLSUM_W-1:0]  sum_bot;
  logic signed [GRAD_W-1:0]    gx;
  logic signed [GRAD_W-1:0]    gy;
  logic signed [2*GRAD_W-1:0]  gxx_full;
  logic signed [2*GRAD_W-1:0]  gyy_full;
  logic signed [2*GRAD_W-1:0]  gxy_full;

  // weighted 1,2,1 sum of three pixels
  function automatic logic [COLSUM_W-1:0] weigh(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
    weigh = COLSUM_W'(a) + {1'b0, b, 1'b0} + COLSUM_W'(c);
  endfunction

  always_comb begin
    sum_left  = weigh(win_top[0], win_mid[0], win_bot[0]);
    sum_right = weigh(win_top[2], win_mid[2], win_bot[2]);
    sum_top   = weigh(win_top[0], win_top[1], win_top[2]);
    sum_bot   = weigh(win_bot[0], win_bot[1], win_bot[2]);
    gx        = signed'({1'b0, sum_right}) - signed'({1'b0, sum_left});
    gy        = signed'({1'b0, sum_bot}) - signed'({1'b0, sum_top});
    gxx_full  = gx * gx;
    gyy_full  = gy * gy;
    gxy_full  = gx * gy;
  end

  logic                    s3_valid;
  logic                    s3_int;
  logic                    s3_end;
  logic        [SQ_W-1:0]  s3_xx;
  logic        [SQ_W-1:0]  s3_yy;
  logic signed [XYP_W-1:0] s3_xy;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_xx  <= gxx_full[SQ_W-1:0];
      s3_yy  <= gyy_full[SQ_W-1:0];
      s3_xy  <= gxy_full[XYP_W-1:0];
      s3_int <= s2_int;
      s3_end <= s2_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  // stage 3: accumulate, hand the sums over at the end of a window
  logic        [SXX_W-1:0] acc_xx;
  logic        [SXX_W-1:0] acc_yy;
  logic signed [SXY_W-1:0] acc_xy;
  logic        [SXX_W-1:0] acc_xx_sum;
  logic        [SXX_W-1:0] acc_yy_sum;
  logic signed [SXY_W-1:0] acc_xy_sum;
  logic                    fin_load;

  always_comb begin
    acc_xx_sum = acc_xx + (s3_int ? SXX_W'(s3_xx) : '0);
    acc_yy_sum = acc_yy + (s3_int ? SXX_W'(s3_yy) : '0);
    acc_xy_sum = acc_xy + (s3_int ? SXY_W'(s3_xy) : '0);
  end

  assign fin_load = s3_valid && s3_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_xx <= '0;
      acc_yy <= '0;
      acc_xy <= '0;
    end else if (s3_valid) begin
      if (s3_end) begin
        acc_xx <= '0;
        acc_yy <= '0;
        acc_xy <= '0;
      end else begin
        acc_xx <= acc_xx_sum;
        acc_yy <= acc_yy_sum;
        acc_xy <= acc_xy_sum;
      end
    end
  end

  // finish sequencer
  logic out_valid;
  logic out_free;
  logic do_mul;
  logic do_sq;
  logic do_kmul;
  logic do_ksum;
  logic do_out;

  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_state <= FIN_IDLE;
    end else begin
      fin_state <= fin_state_next;
    end
  end

  always_comb begin
    fin_state_next = fin_state;
    unique case (fin_state)
      FIN_IDLE: if (fin_load) fin_state_next = FIN_MUL;
      FIN_MUL:  fin_state_next = FIN_SQ;
      FIN_SQ:   fin_state_next = FIN_KMUL;
      FIN_KMUL: fin_state_next = FIN_KSUM;
      FIN_KSUM: fin_state_next = FIN_RESP;
      FIN_RESP: if (out_free) fin_state_next = FIN_IDLE;
      default:  fin_state_next = FIN_IDLE;
    endcase
  end

  always_comb begin
    do_mul  = 1'b0;
    do_sq   = 1'b0;
    do_kmul = 1'b0;
    do_ksum = 1'b0;
    do_out  = 1'b0;
    unique case (fin_state)
      FIN_IDLE: ;
      FIN_MUL:  do_mul  = 1'b1;
      FIN_SQ:   do_sq   = 1'b1;
      FIN_KMUL: do_kmul = 1'b1;
      FIN_KSUM: do_ksum = 1'b1;
      FIN_RESP: do_out  = out_free;
      default: ;
    endcase
  end

  // finish datapath, one multiply per operand pair and step
  logic        [SXX_W-1:0]          f_xx;
  logic        [SXX_W-1:0]          f_yy;
  logic signed [SXY_W-1:0]          f_xy;
  logic        [TRACE_W-1:0]        f_trace;
  logic        [2*SXX_W-1:0]        f_pxx;
  logic signed [2*SXY_W-1:0]        f_pxy;
  logic        [TSQ_W-1:0]          f_tsq;
  logic signed [RESP_W-1:0]         f_det;
  logic        [K_W+TSQ_LO_W-1:0]   f_klo;
  logic        [K_W+TSQ_HI_W-1:0]   f_khi;
  logic        [RESP_W-1:0]         f_kt;

  always_ff @(posedge clk) begin
    if (fin_load) begin
      f_xx <= acc_xx_sum;
      f_yy <= acc_yy_sum;
      f_xy <= acc_xy_sum;
    end
    if (do_mul) begin
      f_trace <= TRACE_W'(f_xx) + TRACE_W'(f_yy);
      f_pxx   <= f_xx * f_yy;
      f_pxy   <= f_xy * f_xy;
    end
    if (do_sq) begin
      f_tsq <= f_trace * f_trace;
      f_det <= RESP_W'(signed'({1'b0, f_pxx})) - RESP_W'(f_pxy);
    end
    // k * trace^2 split into two partial products, over the low 32 and the high 30 bits of trace^2
    if (do_kmul) begin
      f_klo <= cfg_k * f_tsq[TSQ_LO_W-1:0];
      f_khi <= cfg_k * f_tsq[TSQ_W-1:TSQ_LO_W];
    end
    // floor of the product, k being q0.16
    if (do_ksum) begin
      f_kt <= (RESP_W'(f_khi) << (TSQ_LO_W - K_FRAC)) + RESP_W'(f_klo >> K_FRAC);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      results.response <= f_det - signed'(f_kt);
      results.sum_xx   <= f_xx;
      results.sum_yy   <= f_yy;
      results.sum_xy   <= f_xy;
    end
  end

  assign results.valid = out_valid;

  // checks
  `HWR_ASSERT_SAME(a_fin_free_at_load, fin_load, fin_state == FIN_IDLE, "sums handed to busy finish sequencer")
  `HWR_ASSERT_NEXT(a_acc_cleared, fin_load, acc_xx == '0 && acc_yy == '0 && acc_xy == '0, "sums not cleared after window end")
  `HWR_ASSERT_SAME(a_no_ram_collision, in_accept && s1_valid, col_count != s1_col, "row store read and write hit one entry")
  `HWR_ASSERT_SAME(a_out_from_resp, $rose(out_valid), $past(fin_state) == FIN_RESP, "result beat raised outside the last finish step")

endmodule

`default_nettype wire
